/* hdl/meter_response_frame_decoder_defines.svh */
// ---------------------------------------------------------------------------
// meter_response_frame_decoder_defines
// assertion macros shared by the frame decoder modules
// ---------------------------------------------------------------------------
`ifndef METER_RESPONSE_FRAME_DECODER_DEFINES_SVH
`define METER_RESPONSE_FRAME_DECODER_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define MRFD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define MRFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/mrfd_pkg.sv */
// ---------------------------------------------------------------------------
// mrfd_pkg
// types, codes and byte-level helper functions of the meter frame decoder
// ---------------------------------------------------------------------------
`default_nettype none

package mrfd_pkg;

	localparam int VALUE_W = 29;
	localparam int CFG_W   = 15;
	localparam int SLOT_AW = 3;
	localparam int MEM_AW  = SLOT_AW + 1;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// command codes found at frame offset 4
	localparam logic [7:0] CMD_TARIFF = 8'h27;
	localparam logic [7:0] CMD_POWER  = 8'h63;
	localparam logic [7:0] CMD_FREQ   = 8'h81;
	localparam logic [7:0] CMD_CLOCK  = 8'h21;

	// register indexes of the configuration port
	localparam logic [2:0] REG_VOLTAGE_MIN   = 3'd0;
	localparam logic [2:0] REG_VOLTAGE_MAX   = 3'd1;
	localparam logic [2:0] REG_CURRENT_MAX   = 3'd2;
	localparam logic [2:0] REG_FREQUENCY_MIN = 3'd3;
	localparam logic [2:0] REG_FREQUENCY_MAX = 3'd4;

	localparam logic [CFG_W-1:0] RST_VOLTAGE_MIN   = 15'd1900;
	localparam logic [CFG_W-1:0] RST_VOLTAGE_MAX   = 15'd2600;
	localparam logic [CFG_W-1:0] RST_CURRENT_MAX   = 15'd10000;
	localparam logic [CFG_W-1:0] RST_FREQUENCY_MIN = 15'd4500;
	localparam logic [CFG_W-1:0] RST_FREQUENCY_MAX = 15'd5500;

	// quantity codes
	localparam logic [3:0] Q_VOLT    = 4'd0;
	localparam logic [3:0] Q_AMP     = 4'd1;
	localparam logic [3:0] Q_POWER   = 4'd2;
	localparam logic [3:0] Q_ENERGY1 = 4'd3;
	localparam logic [3:0] Q_ENERGY2 = 4'd4;
	localparam logic [3:0] Q_ENERGY3 = 4'd5;
	localparam logic [3:0] Q_TOTAL   = 4'd6;
	localparam logic [3:0] Q_FREQ    = 4'd7;
	localparam logic [3:0] Q_TARIFF  = 4'd8;
	localparam logic [3:0] Q_YEAR    = 4'd9;
	localparam logic [3:0] Q_NONE    = 4'd0;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNKNOWN = 2'd1,
		ST_SHORT   = 2'd2,
		ST_CRC     = 2'd3
	} status_t;

	typedef struct packed {
		logic [CFG_W-1:0] voltage_min;
		logic [CFG_W-1:0] voltage_max;
		logic [CFG_W-1:0] current_max;
		logic [CFG_W-1:0] frequency_min;
		logic [CFG_W-1:0] frequency_max;
	} cfg_t;

	// one decoded frame waiting for its results to be sent
	typedef struct packed {
		status_t     status;
		logic [7:0]  cmd;
		logic [2:0]  nres;
		logic        bank;
		logic [15:0] crc_total;
	} job_t;

	// bank currently written by the intake pipeline
	typedef struct packed {
		logic valid;
		logic bank;
	} busy_t;

	// where a data byte lands in the result slots
	typedef struct packed {
		logic               hit;
		logic [SLOT_AW-1:0] slot;
		logic               first;
		logic               nib;
	} slot_t;

	// one byte through the reflected crc-16 (eight shift steps)
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	// last byte covered by the crc, zero for an unknown command
	function automatic logic [4:0] span_of(input logic [7:0] cmd);
		logic [4:0] s;
		unique case (cmd)
			CMD_TARIFF: s = 5'd20;
			CMD_POWER:  s = 5'd11;
			CMD_FREQ:   s = 5'd14;
			CMD_CLOCK:  s = 5'd11;
			default:    s = 5'd0;
		endcase
		return s;
	endfunction

	// number of results of a good frame
	function automatic logic [2:0] nres_of(input logic [7:0] cmd);
		logic [2:0] n;
		unique case (cmd)
			CMD_TARIFF: n = 3'd4;
			CMD_POWER:  n = 3'd3;
			CMD_FREQ:   n = 3'd2;
			default:    n = 3'd6;
		endcase
		return n;
	endfunction

	// two bcd digits, each nibble taken at its binary value
	function automatic logic [7:0] bcd1(input logic [7:0] b);
		return 8'({4'd0, b[7:4]} * 8'd10 + {4'd0, b[3:0]});
	endfunction

	// quantity of the k-th result of a good frame
	function automatic logic [3:0] quantity_of(input logic [7:0] cmd,
		input logic [SLOT_AW-1:0] k);
		logic [3:0] q;
		unique case (cmd)
			CMD_TARIFF: q = Q_ENERGY1 + {1'b0, k};
			CMD_POWER:  q = Q_VOLT + {1'b0, k};
			CMD_FREQ:   q = Q_FREQ + {1'b0, k};
			default:    q = Q_YEAR + {1'b0, k};
		endcase
		return q;
	endfunction

	// maps a data byte of a known command onto its result slot
	function automatic slot_t slot_map(input logic [7:0] cmd, input logic [7:0] idx);
		slot_t      s;
		logic [7:0] d;
		s = '0;
		d = idx - 8'd5;
		unique case (cmd)
			CMD_TARIFF: begin
				if (idx >= 8'd5 && idx <= 8'd16) begin
					s.hit   = 1'b1;
					s.slot  = {1'b0, d[3:2]};
					s.first = (d[1:0] == 2'd0);
				end
			end
			CMD_POWER: begin
				s.hit = (idx >= 8'd5 && idx <= 8'd11);
				s.slot = (idx <= 8'd6) ? 3'd0 : ((idx <= 8'd8) ? 3'd1 : 3'd2);
				s.first = (idx == 8'd5) || (idx == 8'd7) || (idx == 8'd9);
			end
			CMD_FREQ: begin
				s.hit   = (idx >= 8'd5 && idx <= 8'd7);
				s.slot  = (idx == 8'd7) ? 3'd1 : 3'd0;
				s.first = (idx == 8'd5) || (idx == 8'd7);
				s.nib   = (idx == 8'd7);
			end
			CMD_CLOCK: begin
				s.hit   = (idx >= 8'd6 && idx <= 8'd11);
				s.first = 1'b1;
				unique case (idx)
					8'd6:    s.slot = 3'd3;
					8'd7:    s.slot = 3'd4;
					8'd8:    s.slot = 3'd5;
					8'd9:    s.slot = 3'd2;
					8'd10:   s.slot = 3'd1;
					default: s.slot = 3'd0;
				endcase
			end
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

/* hdl/meter_response_frame_decoder.sv */
// ---------------------------------------------------------------------------
// meter_response_frame_decoder
// decodes bcd meter reply frames with crc-16 check into binary quantity beats
// ---------------------------------------------------------------------------
// Input channel s_axis: one reply byte per beat, tlast on the final byte of a
// frame. Output channel m_axis: one beat per decoded quantity, or a single
// error beat, tlast on the final beat of a frame. Configuration writes are
// taken on any cycle with cfg_we high and should happen while idle.
// Bytes are taken one per cycle while the job queue has room. Each data byte
// is folded into a result slot by a read-modify-write of a small two-bank
// slot memory (registered read, forwarding between back-to-back bytes to the
// same slot). Results pass through the read-data stage and output register
// one per cycle unless stalled, at the rate of the emitter's slot read port.
// One frame can decode while the next is received; the input stalls only
// when a second finished frame waits behind one still being sent, or when
// the receiver stalls long enough. Reset clears counters, crc and queues and
// reloads the limits; the slot memory is not cleared, every used slot is
// written by its frame before it is read. A stalled receiver holds the
// output beat steady and backs up into the job queue.
// ---------------------------------------------------------------------------
`default_nettype none
`include "meter_response_frame_decoder_defines.svh"

module meter_response_frame_decoder #(
	parameter int MAX_FRAME = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // rx_byte
	input  wire         s_axis_tlast,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [55:0] m_axis_tdata,   // command, value, in_range, crc_errors, zero pad
	output logic [5:0]  m_axis_tuser,   // status, quantity
	output logic        m_axis_tlast,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [14:0] cfg_data
);

	localparam int CW = $clog2(MAX_FRAME + 1);
	localparam int VW = mrfd_pkg::VALUE_W;
	localparam int AW = mrfd_pkg::MEM_AW;

	// frame state
	logic [CW-1:0]  count_q;
	logic [15:0]    crc_q, cap_q, err_total_q;
	logic [7:0]     cmd_q, crc_lo_q, crc_hi_q;
	logic           bank_q;
	mrfd_pkg::cfg_t cfg_q;

	// slot update stage
	logic           s1_valid_q, s1_first_q, s1_fwd_q;
	logic [AW-1:0]  s1_addr_q;
	logic [7:0]     s1_digit_q;
	logic [VW-1:0]  wr_data_q;

	// slot memory, two banks of result slots
	logic [VW-1:0]  slot_mem [0:(1 << AW) - 1];
	logic [VW-1:0]  rd_a_q, rd_b_q;

	logic              accept, in_frame, job_push, job_room, rd_en;
	logic [AW-1:0]     rd_addr;
	logic [7:0]        idx, cmd_n, crc_lo_n, crc_hi_n, span8, digit;
	logic [CW-1:0]     count_n;
	logic [15:0]       crc_n, cap_n;
	logic [4:0]        span;
	mrfd_pkg::slot_t   sm;
	logic [AW-1:0]     a_addr;
	logic [VW-1:0]     s1_old, s1_new;
	mrfd_pkg::job_t    job;
	mrfd_pkg::busy_t   wr_busy;
	logic              long_enough;

	// next frame state for the byte on the input
	always_comb begin
		accept   = s_axis_tvalid && s_axis_tready;
		idx      = 8'(count_q);
		in_frame = (count_q < CW'(MAX_FRAME));
		count_n  = in_frame ? count_q + CW'(1) : count_q;
		cmd_n    = (in_frame && idx == 8'd4) ? s_axis_tdata : cmd_q;
		crc_n    = in_frame ? mrfd_pkg::crc_byte(crc_q, s_axis_tdata) : crc_q;
		span8    = {3'd0, mrfd_pkg::span_of(cmd_q)};
		cap_n    = (in_frame && idx >= 8'd5 && idx == span8) ? crc_n : cap_q;
		crc_lo_n = (in_frame && idx >= 8'd5 && idx == span8 + 8'd1) ? s_axis_tdata : crc_lo_q;
		crc_hi_n = (in_frame && idx >= 8'd5 && idx == span8 + 8'd2) ? s_axis_tdata : crc_hi_q;
		sm       = mrfd_pkg::slot_map(cmd_q, idx);
		a_addr   = {bank_q, sm.slot};
		digit    = sm.nib ? {4'd0, s_axis_tdata[3:0]} : mrfd_pkg::bcd1(s_axis_tdata);
	end

	// verdict on a frame at its final byte
	always_comb begin
		long_enough = (8'(count_n) >= 8'd5);
		span        = long_enough ? mrfd_pkg::span_of(cmd_n) : 5'd0;
		job.cmd       = long_enough ? cmd_n : 8'd0;
		job.bank      = bank_q;
		job.nres      = 3'd1;
		job.crc_total = err_total_q;
		if (span == 5'd0) begin
			job.status = mrfd_pkg::ST_UNKNOWN;
		end else if (8'(count_n) < {3'd0, span} + 8'd3) begin
			job.status = mrfd_pkg::ST_SHORT;
		end else if (cap_n != {crc_hi_n, crc_lo_n}) begin
			job.status = mrfd_pkg::ST_CRC;
			if (err_total_q != 16'hFFFF) begin
				job.crc_total = err_total_q + 16'd1;
			end
		end else begin
			job.status = mrfd_pkg::ST_OK;
			job.nres   = mrfd_pkg::nres_of(cmd_n);
		end
		job_push      = accept && s_axis_tlast;
		s_axis_tready = job_room;
	end

	// frame counters, crc and capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			crc_q       <= mrfd_pkg::CRC_INIT;
			cap_q       <= '0;
			err_total_q <= '0;
			bank_q      <= 1'b0;
			cmd_q       <= '0;
			crc_lo_q    <= '0;
			crc_hi_q    <= '0;
		end else if (accept) begin
			cmd_q    <= cmd_n;
			crc_lo_q <= crc_lo_n;
			crc_hi_q <= crc_hi_n;
			if (s_axis_tlast) begin
				count_q     <= '0;
				crc_q       <= mrfd_pkg::CRC_INIT;
				cap_q       <= '0;
				err_total_q <= job.crc_total;
				bank_q      <= !bank_q;
			end else begin
				count_q <= count_n;
				crc_q   <= crc_n;
				cap_q   <= cap_n;
			end
		end
	end

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.voltage_min   <= mrfd_pkg::RST_VOLTAGE_MIN;
			cfg_q.voltage_max   <= mrfd_pkg::RST_VOLTAGE_MAX;
			cfg_q.current_max   <= mrfd_pkg::RST_CURRENT_MAX;
			cfg_q.frequency_min <= mrfd_pkg::RST_FREQUENCY_MIN;
			cfg_q.frequency_max <= mrfd_pkg::RST_FREQUENCY_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mrfd_pkg::REG_VOLTAGE_MIN:   cfg_q.voltage_min   <= cfg_data;
				mrfd_pkg::REG_VOLTAGE_MAX:   cfg_q.voltage_max   <= cfg_data;
				mrfd_pkg::REG_CURRENT_MAX:   cfg_q.current_max   <= cfg_data;
				mrfd_pkg::REG_FREQUENCY_MIN: cfg_q.frequency_min <= cfg_data;
				mrfd_pkg::REG_FREQUENCY_MAX: cfg_q.frequency_max <= cfg_data;
				default: ;
			endcase
		end
	end

	// slot update stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept && sm.hit;
		end
	end

	// slot update stage payload, forward when the previous byte hit the same slot
	always_ff @(posedge clk) begin
		if (accept && sm.hit) begin
			s1_addr_q  <= a_addr;
			s1_first_q <= sm.first;
			s1_digit_q <= digit;
			s1_fwd_q   <= s1_valid_q && (s1_addr_q == a_addr);
		end
		if (s1_valid_q) begin
			wr_data_q <= s1_new;
		end
	end

	// new slot value: start with the digit pair or append it
	always_comb begin
		s1_old = s1_fwd_q ? wr_data_q : rd_a_q;
		s1_new = s1_first_q ? VW'(s1_digit_q) :
			VW'(36'(s1_old) * 36'd100 + 36'(s1_digit_q));
		wr_busy.valid = s1_valid_q;
		wr_busy.bank  = s1_addr_q[AW-1];
	end

	// slot memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			slot_mem[s1_addr_q] <= s1_new;
		end
		if (accept && sm.hit) begin
			rd_a_q <= slot_mem[a_addr];
		end
		if (rd_en) begin
			rd_b_q <= slot_mem[rd_addr];
		end
	end

	mrfd_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_push      (job_push),
		.job_in        (job),
		.job_room      (job_room),
		.wr_busy       (wr_busy),
		.cfg           (cfg_q),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_b_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	`MRFD_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(MAX_FRAME), "byte count beyond frame limit")
	`MRFD_ASSERT_NEXT(a_frame_restart, accept && s_axis_tlast, count_q == '0 && crc_q == mrfd_pkg::CRC_INIT, "frame state not restarted after final byte")
	`MRFD_ASSERT_IMP(a_forward_source, s1_valid_q && s1_fwd_q, $past(s1_valid_q) && $past(s1_addr_q) == s1_addr_q, "forwarded slot value without a write to that slot")

endmodule

`default_nettype wire

/* hdl/mrfd_emit.sv */
// ---------------------------------------------------------------------------
// mrfd_emit
// result sequencer: job queue, slot reads and the output register
// ---------------------------------------------------------------------------
`default_nettype none
`include "meter_response_frame_decoder_defines.svh"

module mrfd_emit (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           job_push,
	input  mrfd_pkg::job_t                job_in,
	output logic                          job_room,
	input  mrfd_pkg::busy_t               wr_busy,
	input  mrfd_pkg::cfg_t                cfg,
	output logic                          rd_en,
	output logic [mrfd_pkg::MEM_AW-1:0]   rd_addr,
	input  wire  [mrfd_pkg::VALUE_W-1:0]  rd_data,
	output logic                          m_axis_tvalid,
	input  wire                           m_axis_tready,
	output logic [55:0]                   m_axis_tdata,   // command, value, in_range, crc_errors
	output logic [5:0]                    m_axis_tuser,   // status, quantity
	output logic                          m_axis_tlast
);

	localparam int VW = mrfd_pkg::VALUE_W;
	localparam int SW = mrfd_pkg::SLOT_AW;

	// job queue: active job and one waiting behind it
	logic           act_valid_q, pend_valid_q;
	mrfd_pkg::job_t act_q, pend_q;
	logic [SW-1:0]  k_q;

	// read-data stage
	logic                 e2_valid_q, e2_ok_q, e2_last_q;
	mrfd_pkg::status_t    e2_status_q;
	logic [7:0]           e2_cmd_q;
	logic [3:0]           e2_quantity_q;
	logic [15:0]          e2_crc_total_q;

	// output register
	logic                 out_valid_q, out_range_q, out_last_q;
	mrfd_pkg::status_t    out_status_q;
	logic [7:0]           out_cmd_q;
	logic [3:0]           out_quantity_q;
	logic [VW-1:0]        out_value_q;
	logic [15:0]          out_crc_total_q;

	logic [VW-1:0]        sum_q;

	logic          out_load, issue, act_last_k, act_done, act_load, blocked;
	logic [VW-1:0] e2_value;
	logic          e2_range;

	// plausibility limits per quantity
	function automatic logic range_ok(input logic [3:0] q, input logic [VW-1:0] v,
		input mrfd_pkg::cfg_t c);
		logic r;
		unique case (q)
			mrfd_pkg::Q_VOLT:   r = (v >= VW'(c.voltage_min)) && (v <= VW'(c.voltage_max));
			mrfd_pkg::Q_AMP:    r = (v <= VW'(c.current_max));
			mrfd_pkg::Q_FREQ:   r = (v >= VW'(c.frequency_min)) && (v <= VW'(c.frequency_max));
			mrfd_pkg::Q_TARIFF: r = (v >= VW'(1)) && (v <= VW'(4));
			default:            r = 1'b1;
		endcase
		return r;
	endfunction

	// handshake between stages and the write interlock
	always_comb begin
		out_load   = e2_valid_q && (!out_valid_q || m_axis_tready);
		blocked    = wr_busy.valid && (wr_busy.bank == act_q.bank);
		issue      = act_valid_q && (!e2_valid_q || out_load) && !blocked;
		act_last_k = (k_q == act_q.nres - 3'd1);
		act_done   = issue && act_last_k;
		act_load   = job_push && (!act_valid_q || act_done);
		job_room   = !pend_valid_q;
		rd_en      = issue;
		rd_addr    = {act_q.bank, k_q};
	end

	// value and range of the result in the read-data stage
	always_comb begin
		if (!e2_ok_q) begin
			e2_value = '0;
		end else if (e2_quantity_q == mrfd_pkg::Q_TOTAL) begin
			e2_value = sum_q;
		end else begin
			e2_value = rd_data;
		end
		e2_range = e2_ok_q && range_ok(e2_quantity_q, e2_value, cfg);
	end

	// job queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			k_q          <= '0;
		end else begin
			if (act_load) begin
				act_valid_q <= 1'b1;
			end else if (job_push) begin
				pend_valid_q <= 1'b1;
			end else if (act_done) begin
				act_valid_q  <= pend_valid_q;
				pend_valid_q <= 1'b0;
			end
			if (act_load || act_done) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + SW'(1);
			end
		end
	end

	// job payload
	always_ff @(posedge clk) begin
		if (act_load) begin
			act_q <= job_in;
		end else if (job_push) begin
			pend_q <= job_in;
		end else if (act_done) begin
			act_q <= pend_q;
		end
	end

	// read-data stage and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				e2_valid_q <= 1'b1;
			end else if (out_load) begin
				e2_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload of the read-data stage, output beat and tariff sum
	always_ff @(posedge clk) begin
		if (issue) begin
			e2_ok_q        <= (act_q.status == mrfd_pkg::ST_OK);
			e2_last_q      <= act_last_k;
			e2_status_q    <= act_q.status;
			e2_cmd_q       <= act_q.cmd;
			e2_quantity_q  <= (act_q.status == mrfd_pkg::ST_OK) ?
				mrfd_pkg::quantity_of(act_q.cmd, k_q) : mrfd_pkg::Q_NONE;
			e2_crc_total_q <= act_q.crc_total;
		end
		if (out_load) begin
			out_status_q    <= e2_status_q;
			out_cmd_q       <= e2_cmd_q;
			out_quantity_q  <= e2_quantity_q;
			out_value_q     <= e2_value;
			out_range_q     <= e2_range;
			out_crc_total_q <= e2_crc_total_q;
			out_last_q      <= e2_last_q;
			if (e2_ok_q && e2_quantity_q == mrfd_pkg::Q_ENERGY1) begin
				sum_q <= e2_value;
			end else if (e2_ok_q && (e2_quantity_q == mrfd_pkg::Q_ENERGY2 ||
				e2_quantity_q == mrfd_pkg::Q_ENERGY3)) begin
				sum_q <= VW'(sum_q + e2_value);
			end
		end
	end

	// output beat
	always_comb begin
		m_axis_tvalid = out_valid_q;
		m_axis_tdata  = {2'b00, out_crc_total_q, out_range_q, out_value_q, out_cmd_q};
		m_axis_tuser  = {out_quantity_q, out_status_q};
		m_axis_tlast  = out_last_q;
	end

	`MRFD_ASSERT_IMP(a_pend_behind_act, pend_valid_q, act_valid_q, "waiting job without an active one")
	`MRFD_ASSERT_IMP(a_banks_differ, pend_valid_q, pend_q.bank != act_q.bank, "queued jobs share a bank")
	`MRFD_ASSERT_IMP(a_no_read_under_write, issue && wr_busy.valid, wr_busy.bank != act_q.bank, "slot read of a bank still being written")
	`MRFD_ASSERT_IMP(a_error_beat, out_valid_q && out_status_q != mrfd_pkg::ST_OK, out_last_q && out_value_q == '0, "error beat not final or not zero")

endmodule

`default_nettype wire
